FILE: rtl/igmm_pkg.sv
// Shared constants, register codes and types for the image gradient min/max tracker.
package igmm_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_LIMIT  = 4096;

	localparam int PIX_W      = 8;
	localparam int DIFF_W     = PIX_W + 1;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = HEIGHT_W;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// Per-pixel position flags handed from the frame counters to the pipeline.
	typedef struct packed {
		logic dx_en;
		logic dy_en;
		logic frame_end;
	} pos_flags_t;

endpackage

FILE: rtl/igmm_if.sv
// Channel interfaces: pixel input, result output and configuration write.
interface igmm_pixel_if import igmm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface igmm_result_if import igmm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DIFF_W-1:0] max_dx;
	logic signed [DIFF_W-1:0] min_dx;
	logic signed [DIFF_W-1:0] max_dy;
	logic signed [DIFF_W-1:0] min_dy;
	logic                     dx_found;
	logic                     dy_found;

	modport source (output valid, output max_dx, output min_dx, output max_dy,
		output min_dy, output dx_found, output dy_found, input ready);
	modport sink   (input valid, input max_dx, input min_dx, input max_dy,
		input min_dy, input dx_found, input dy_found, output ready);
endinterface

interface igmm_cfg_if import igmm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/igmm_line_store.sv
// Two-row line store: one write port, one read port with registered read data.
module igmm_line_store import igmm_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [2*PIX_W-1:0]  rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [2*PIX_W-1:0]  wr_data
);

	logic [2*PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read returns the old contents on a same-address write; the caller forwards.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/igmm_frame_ctl.sv
// Configuration registers and column/row position counters of the frame.
module igmm_frame_ctl import igmm_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	igmm_cfg_if.sink                     cfg,
	input  logic                         advance,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output pos_flags_t                   flags
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	logic [EW-1:0]       width_ext;
	logic [EW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                row_end;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data[WIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg.data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers into the usable range.
	always_comb begin
		width_ext = EW'(width_q);
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = width_ext;
		end
		if (height_q == '0) begin
			h_eff = HEIGHT_W'(1);
		end else if (height_q > HEIGHT_W'(HEIGHT_LIMIT)) begin
			h_eff = HEIGHT_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
	end

	assign row_end         = (EW'(col_q) + EW'(1)) >= w_eff;
	assign flags.frame_end = row_end && ((HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= h_eff);
	assign flags.dx_en     = col_q >= CW'(2);
	assign flags.dy_en     = row_q >= ROW_W'(2);
	assign col             = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (flags.frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

FILE: rtl/igmm_tracker.sv
// Running dx/dy extremes and the registered frame result.
module igmm_tracker import igmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic                     pending_end,
	input  pos_flags_t               flags,
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	output logic                     stall,
	igmm_result_if.source            results
);

	logic signed [DIFF_W-1:0] dx_hi_q, dx_lo_q, dy_hi_q, dy_lo_q;
	logic                     dx_seen_q, dy_seen_q;
	logic signed [DIFF_W-1:0] dx_hi_n, dx_lo_n, dy_hi_n, dy_lo_n;
	logic                     dx_seen_n, dy_seen_n;

	logic                     out_valid_q;
	logic signed [DIFF_W-1:0] max_dx_q, min_dx_q, max_dy_q, min_dy_q;
	logic                     dx_found_q, dy_found_q;

	always_comb begin
		dx_hi_n   = dx_hi_q;
		dx_lo_n   = dx_lo_q;
		dx_seen_n = dx_seen_q;
		dy_hi_n   = dy_hi_q;
		dy_lo_n   = dy_lo_q;
		dy_seen_n = dy_seen_q;
		if (flags.dx_en) begin
			if (!dx_seen_q) begin
				dx_hi_n   = dx;
				dx_lo_n   = dx;
				dx_seen_n = 1'b1;
			end else begin
				if (dx > dx_hi_q) dx_hi_n = dx;
				if (dx < dx_lo_q) dx_lo_n = dx;
			end
		end
		if (flags.dy_en) begin
			if (!dy_seen_q) begin
				dy_hi_n   = dy;
				dy_lo_n   = dy;
				dy_seen_n = 1'b1;
			end else begin
				if (dy > dy_hi_q) dy_hi_n = dy;
				if (dy < dy_lo_q) dy_lo_n = dy;
			end
		end
	end

	// Hold a frame-end item while the previous result is still unread.
	assign stall = pending_end && out_valid_q && !results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_hi_q   <= '0;
			dx_lo_q   <= '0;
			dy_hi_q   <= '0;
			dy_lo_q   <= '0;
			dx_seen_q <= 1'b0;
			dy_seen_q <= 1'b0;
		end else if (go) begin
			if (flags.frame_end) begin
				dx_hi_q   <= '0;
				dx_lo_q   <= '0;
				dy_hi_q   <= '0;
				dy_lo_q   <= '0;
				dx_seen_q <= 1'b0;
				dy_seen_q <= 1'b0;
			end else begin
				dx_hi_q   <= dx_hi_n;
				dx_lo_q   <= dx_lo_n;
				dy_hi_q   <= dy_hi_n;
				dy_lo_q   <= dy_lo_n;
				dx_seen_q <= dx_seen_n;
				dy_seen_q <= dy_seen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && flags.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && flags.frame_end) begin
			max_dx_q   <= dx_seen_n ? dx_hi_n : '0;
			min_dx_q   <= dx_seen_n ? dx_lo_n : '0;
			max_dy_q   <= dy_seen_n ? dy_hi_n : '0;
			min_dy_q   <= dy_seen_n ? dy_lo_n : '0;
			dx_found_q <= dx_seen_n;
			dy_found_q <= dy_seen_n;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.max_dx   = max_dx_q;
	assign results.min_dx   = min_dx_q;
	assign results.max_dy   = max_dy_q;
	assign results.min_dy   = min_dy_q;
	assign results.dx_found = dx_found_q;
	assign results.dy_found = dy_found_q;

endmodule

FILE: rtl/image_gradient_min_max_tracker.sv
// Top level of the image gradient min/max tracker: counters, line store, tracker.
// Throughput: one pixel per cycle while the input is not stalled, set by the single
// read-modify-write of the line store per pixel. A frame result is registered once its
// last pixel has passed stage 1 (line store read at acceptance, then compare and load).
// Input stalls only while a frame-end pixel waits on an unread earlier result.
// Reset: asynchronous, clears counters, extremes and valids; line store is not cleared.
module image_gradient_min_max_tracker import igmm_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	igmm_cfg_if.sink      cfg,
	igmm_pixel_if.sink    pixels,
	igmm_result_if.source results
);

	localparam int CW = $clog2(MAX_WIDTH);

	// Stage 0: accept the pixel, read its column of the line store.
	logic               accept;
	logic [CW-1:0]      col_now;
	pos_flags_t         flags_now;
	logic [PIX_W-1:0]   pd1_q, pd2_q;

	// Stage 1: line store data is back; form the differences and write back.
	logic               valid_s1;
	logic [CW-1:0]      col_s1;
	pos_flags_t         flags_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic [PIX_W-1:0]   pd2_s1;
	logic               fwd_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;

	logic               s1_go;
	logic               stall;
	logic [2*PIX_W-1:0] rd_data;
	logic [2*PIX_W-1:0] entry;
	logic [2*PIX_W-1:0] wr_data;
	logic signed [DIFF_W-1:0] dx, dy;

	assign accept       = pixels.valid && pixels.ready;
	assign pixels.ready = !stall;
	assign s1_go        = valid_s1 && !stall;

	igmm_frame_ctl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_frame_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.col     (col_now),
		.flags   (flags_now)
	);

	// Shift the last two pixels of the stream on every transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd1_q <= '0;
			pd2_q <= '0;
		end else if (accept) begin
			pd1_q <= pixels.pixel;
			pd2_q <= pd1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// The memory returns stale data when stage 1 writes the very column that
	// stage 0 reads in the same cycle (a one-pixel-wide frame); forward it.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_now;
			flags_s1    <= flags_now;
			pixel_s1    <= pixels.pixel;
			pd2_s1      <= pd2_q;
			fwd_s1      <= s1_go && (col_s1 == col_now);
			fwd_data_s1 <= wr_data;
		end
	end

	igmm_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_now),
		.rd_data (rd_data),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	// Entry: low byte is the row above, high byte two rows above.
	// Advance it: the row above moves up, the current pixel becomes the row above.
	assign entry   = fwd_s1 ? fwd_data_s1 : rd_data;
	assign wr_data = {entry[PIX_W-1:0], pixel_s1};

	assign dx = $signed({1'b0, pd2_s1}) - $signed({1'b0, pixel_s1});
	assign dy = $signed({1'b0, entry[2*PIX_W-1:PIX_W]}) - $signed({1'b0, pixel_s1});

	igmm_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (s1_go),
		.pending_end (valid_s1 && flags_s1.frame_end),
		.flags       (flags_s1),
		.dx          (dx),
		.dy          (dy),
		.stall       (stall),
		.results     (results)
	);

	// Forwarding only occurs when the row is a single column wide.
	a_fwd_col0: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> col_s1 == '0)
		else $error("line store forward at nonzero column");

	// The column in flight always addresses a real line store entry.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> 32'(col_s1) < MAX_WIDTH)
		else $error("column beyond line store depth");

	// Loading a result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && flags_s1.frame_end && results.valid |-> results.ready)
		else $error("frame result overwritten");

	// A stalled input always has a frame-end item parked in stage 1.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> valid_s1 && flags_s1.frame_end && results.valid)
		else $error("input stalled without pending result");

endmodule
